[design/ocfb_pkg.sv]
// ----------------------------------------------------------------------------
// ocfb_pkg
// Types, codes and size constants shared by the OLED command/frame store core.
// ----------------------------------------------------------------------------
package ocfb_pkg;

  localparam int COLUMNS_DEF        = 132;
  localparam int PAGES_DEF          = 8;
  localparam int VISIBLE_WIDTH_DEF  = 96;
  localparam int VISIBLE_HEIGHT_DEF = 16;
  localparam int COLUMN_OFFSET_DEF  = 36;
  localparam int QUEUE_DEPTH_DEF    = 4;

  // address field sized for the largest store (255 columns x 8 pages)
  localparam int FB_ADDR_W = $clog2(255 * 8);

  localparam logic [2:0] OP_BUS_BYTE   = 3'd0;
  localparam logic [2:0] OP_BUS_FINISH = 3'd1;
  localparam logic [2:0] OP_READ_PIXEL = 3'd2;
  localparam logic [2:0] OP_FRAME_TAKEN = 3'd3;
  localparam logic [2:0] OP_INVALIDATE = 3'd4;

  localparam logic [1:0] LINK_IDLE = 2'd0;
  localparam logic [1:0] LINK_DATA = 2'd1;
  localparam logic [1:0] LINK_CMD  = 2'd2;

  localparam logic [7:0] CTRL_CMD  = 8'h80;
  localparam logic [7:0] CTRL_DATA = 8'h40;

  localparam logic [7:0] CMD_COL_LO_FIRST  = 8'h00;
  localparam logic [7:0] CMD_COL_LO_LAST   = 8'h0f;
  localparam logic [7:0] CMD_COL_HI_FIRST  = 8'h10;
  localparam logic [7:0] CMD_COL_HI_LAST   = 8'h20;
  localparam logic [7:0] CMD_START_FIRST   = 8'h40;
  localparam logic [7:0] CMD_START_LAST    = 8'h7f;
  localparam logic [7:0] CMD_PAGE_FIRST    = 8'hb0;
  localparam logic [7:0] CMD_PAGE_LAST     = 8'hbf;
  localparam logic [7:0] CMD_SCAN_FIRST    = 8'hc0;
  localparam logic [7:0] CMD_SCAN_LAST     = 8'hc8;

  localparam logic [7:0] CMD_CONTRAST      = 8'h81;
  localparam logic [7:0] CMD_MUX_RATIO     = 8'ha8;
  localparam logic [7:0] CMD_DCDC          = 8'had;
  localparam logic [7:0] CMD_DISP_OFFSET   = 8'hd3;
  localparam logic [7:0] CMD_CLOCK_DIV     = 8'hd5;
  localparam logic [7:0] CMD_AREA_COLOR    = 8'hd8;
  localparam logic [7:0] CMD_PRECHARGE     = 8'hd9;
  localparam logic [7:0] CMD_COLOR_MODE    = 8'hda;
  localparam logic [7:0] CMD_COM_PINS      = 8'hdb;
  localparam logic [7:0] CMD_MIRROR_OFF    = 8'ha0;
  localparam logic [7:0] CMD_MIRROR_ON     = 8'ha1;
  localparam logic [7:0] CMD_ALL_ON_OFF    = 8'ha4;
  localparam logic [7:0] CMD_ALL_ON_ON     = 8'ha5;
  localparam logic [7:0] CMD_NORMAL        = 8'ha6;
  localparam logic [7:0] CMD_INVERSE       = 8'ha7;
  localparam logic [7:0] CMD_DISP_OFF      = 8'hae;
  localparam logic [7:0] CMD_DISP_ON       = 8'haf;
  localparam logic [7:0] CMD_NOP           = 8'he3;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] byte_value;
    logic [6:0] pixel_x;
    logic [3:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic       pixel_on;
    logic       redraw_pending;
    logic       protocol_error;
    logic [1:0] link_mode;
    logic       display_enabled;
    logic       mirror_on;
  } out_word_t;

  typedef struct packed {
    logic                 mem_we;
    logic                 mem_re;
    logic                 force_on;
    logic                 invert;
    logic [FB_ADDR_W-1:0] addr;
    logic [7:0]           wdata;
    logic [2:0]           bit_sel;
    logic                 dirty;
    logic                 err;
    logic [1:0]           link;
    logic                 enable;
    logic                 mirror;
  } fb_entry_t;

endpackage

[design/ocfb_stream_if.sv]
// ----------------------------------------------------------------------------
// ocfb_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface ocfb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[design/ocfb_front.sv]
// ----------------------------------------------------------------------------
// ocfb_front
// Accepts words, runs the link/command decoder and builds store requests.
// ----------------------------------------------------------------------------
module ocfb_front #(
  parameter int COLUMNS        = ocfb_pkg::COLUMNS_DEF,
  parameter int PAGES          = ocfb_pkg::PAGES_DEF,
  parameter int VISIBLE_WIDTH  = ocfb_pkg::VISIBLE_WIDTH_DEF,
  parameter int VISIBLE_HEIGHT = ocfb_pkg::VISIBLE_HEIGHT_DEF,
  parameter int COLUMN_OFFSET  = ocfb_pkg::COLUMN_OFFSET_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  ocfb_stream_if.sink         in_chan,
  input  logic                store_ready,
  input  logic                q_full,
  output logic                q_push,
  output ocfb_pkg::fb_entry_t q_entry
);
  import ocfb_pkg::*;

  logic [7:0] col_ptr_r, col_ptr_nxt;
  logic [2:0] page_ptr_r, page_ptr_nxt;
  logic [1:0] link_r, link_nxt;
  logic       skip_r, skip_nxt;
  logic       mirror_r, mirror_nxt;
  logic       entire_r, entire_nxt;
  logic       enable_r, enable_nxt;
  logic       inverse_r, inverse_nxt;
  logic       dirty_r, dirty_nxt;

  in_word_t   word;
  logic       accept;
  logic       err;
  logic [8:0] pix_col;
  logic [2:0] pix_page;
  logic       pix_in_window;

  assign word           = in_chan.payload;
  assign in_chan.ready  = store_ready && !q_full;
  assign accept         = in_chan.valid && in_chan.ready;
  assign q_push         = accept;

  assign pix_col  = {2'b00, word.pixel_x} + 9'(COLUMN_OFFSET);
  assign pix_page = {2'b00, word.pixel_y[3]};
  assign pix_in_window = ({1'b0, word.pixel_x} < 8'(VISIBLE_WIDTH)) &&
                         ({3'b000, word.pixel_y} < 7'(VISIBLE_HEIGHT)) &&
                         ({1'b0, pix_page} < 4'(PAGES)) &&
                         (pix_col < 9'(COLUMNS));

  always_comb begin
    col_ptr_nxt  = col_ptr_r;
    page_ptr_nxt = page_ptr_r;
    link_nxt     = link_r;
    skip_nxt     = skip_r;
    mirror_nxt   = mirror_r;
    entire_nxt   = entire_r;
    enable_nxt   = enable_r;
    inverse_nxt  = inverse_r;
    dirty_nxt    = dirty_r;
    err          = 1'b0;
    q_entry      = '0;
    q_entry.wdata = word.byte_value;

    case (word.opcode)
      OP_BUS_BYTE: begin
        if (link_r == LINK_DATA) begin
          if ((col_ptr_r < 8'(COLUMNS)) && ({1'b0, page_ptr_r} < 4'(PAGES))) begin
            q_entry.mem_we = 1'b1;
            q_entry.addr   = FB_ADDR_W'(page_ptr_r) * FB_ADDR_W'(COLUMNS) +
                             FB_ADDR_W'(col_ptr_r);
            col_ptr_nxt    = col_ptr_r + 8'd1;
            dirty_nxt      = 1'b1;
          end
        end else if (link_r == LINK_CMD) begin
          if (skip_r) begin
            skip_nxt = 1'b0;
          end else begin
            link_nxt = LINK_IDLE;
            if (word.byte_value inside {[CMD_COL_LO_FIRST:CMD_COL_LO_LAST]}) begin
              col_ptr_nxt = {col_ptr_r[7:4], word.byte_value[3:0]};
            end else if (word.byte_value inside {[CMD_COL_HI_FIRST:CMD_COL_HI_LAST]}) begin
              col_ptr_nxt = {word.byte_value[3:0], col_ptr_r[3:0]};
            end else if (word.byte_value inside {[CMD_START_FIRST:CMD_START_LAST]}) begin
              // start line stays zero
            end else if (word.byte_value inside {[CMD_PAGE_FIRST:CMD_PAGE_LAST]}) begin
              page_ptr_nxt = word.byte_value[2:0];
            end else if (word.byte_value inside {[CMD_SCAN_FIRST:CMD_SCAN_LAST]}) begin
              // scan direction ignored
            end else begin
              case (word.byte_value)
                CMD_CONTRAST, CMD_MUX_RATIO, CMD_DCDC, CMD_DISP_OFFSET,
                CMD_CLOCK_DIV, CMD_AREA_COLOR, CMD_PRECHARGE, CMD_COLOR_MODE,
                CMD_COM_PINS: begin
                  skip_nxt = 1'b1;
                end
                CMD_MIRROR_OFF: mirror_nxt  = 1'b0;
                CMD_MIRROR_ON:  mirror_nxt  = 1'b1;
                CMD_ALL_ON_OFF: entire_nxt  = 1'b0;
                CMD_ALL_ON_ON:  entire_nxt  = 1'b1;
                CMD_NORMAL:     inverse_nxt = 1'b0;
                CMD_INVERSE:    inverse_nxt = 1'b1;
                CMD_DISP_OFF:   enable_nxt  = 1'b0;
                CMD_DISP_ON:    enable_nxt  = 1'b1;
                CMD_NOP: begin
                end
                default: err = 1'b1;
              endcase
            end
          end
        end else begin
          if (word.byte_value == CTRL_CMD) begin
            link_nxt = LINK_CMD;
          end else if (word.byte_value == CTRL_DATA) begin
            link_nxt = LINK_DATA;
          end else begin
            err = 1'b1;
          end
        end
      end
      OP_BUS_FINISH: begin
        link_nxt = LINK_IDLE;
      end
      OP_READ_PIXEL: begin
        if (pix_in_window) begin
          if (entire_r) begin
            q_entry.force_on = 1'b1;
          end else begin
            q_entry.mem_re  = 1'b1;
            q_entry.invert  = inverse_r;
            q_entry.bit_sel = word.pixel_y[2:0];
            q_entry.addr    = FB_ADDR_W'(pix_page) * FB_ADDR_W'(COLUMNS) +
                              FB_ADDR_W'(pix_col);
          end
        end
      end
      OP_FRAME_TAKEN: begin
        dirty_nxt = 1'b0;
      end
      OP_INVALIDATE: begin
        dirty_nxt = 1'b1;
      end
      default: begin
      end
    endcase

    q_entry.dirty  = dirty_nxt;
    q_entry.err    = err;
    q_entry.link   = link_nxt;
    q_entry.enable = enable_nxt;
    q_entry.mirror = mirror_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_ptr_r  <= '0;
      page_ptr_r <= '0;
      link_r     <= LINK_IDLE;
      skip_r     <= 1'b0;
      mirror_r   <= 1'b0;
      entire_r   <= 1'b0;
      enable_r   <= 1'b0;
      inverse_r  <= 1'b0;
      dirty_r    <= 1'b0;
    end else if (accept) begin
      col_ptr_r  <= col_ptr_nxt;
      page_ptr_r <= page_ptr_nxt;
      link_r     <= link_nxt;
      skip_r     <= skip_nxt;
      mirror_r   <= mirror_nxt;
      entire_r   <= entire_nxt;
      enable_r   <= enable_nxt;
      inverse_r  <= inverse_nxt;
      dirty_r    <= dirty_nxt;
    end
  end

endmodule

[design/ocfb_queue.sv]
// ----------------------------------------------------------------------------
// ocfb_queue
// Short request queue between the decoder and the frame store side.
// ----------------------------------------------------------------------------
module ocfb_queue #(
  parameter int QUEUE_DEPTH = ocfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ocfb_pkg::fb_entry_t push_entry,
  input  logic                pop,
  output ocfb_pkg::fb_entry_t head_entry,
  output logic                empty,
  output logic                full
);
  import ocfb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fb_entry_t        slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign empty      = (count_r == '0);
  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[design/ocfb_back.sv]
// ----------------------------------------------------------------------------
// ocfb_back
// Frame store memory with clearing pass, request execution and result word.
// ----------------------------------------------------------------------------
module ocfb_back #(
  parameter int COLUMNS = ocfb_pkg::COLUMNS_DEF,
  parameter int PAGES   = ocfb_pkg::PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ocfb_pkg::fb_entry_t head_entry,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                store_ready,
  ocfb_stream_if.source       out_chan
);
  import ocfb_pkg::*;

  localparam int MEM_DEPTH = COLUMNS * PAGES;
  localparam int AW        = $clog2(MEM_DEPTH);

  logic [7:0]    fb_mem_r [MEM_DEPTH];
  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;
  logic [7:0]    rd_data_r;
  fb_entry_t     out_entry_r;
  logic          out_valid_r;
  out_word_t     result;

  assign store_ready = !clearing_r;
  assign q_pop       = !clearing_r && !q_empty && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      fb_mem_r[clr_addr_r] <= '0;
    end else if (q_pop && head_entry.mem_we) begin
      fb_mem_r[head_entry.addr[AW-1:0]] <= head_entry.wdata;
    end
    if (q_pop && head_entry.mem_re) begin
      rd_data_r <= fb_mem_r[head_entry.addr[AW-1:0]];
    end
    if (q_pop) begin
      out_entry_r <= head_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        if (clr_addr_r == AW'(MEM_DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + AW'(1);
        end
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    result.pixel_on        = out_entry_r.mem_re ?
                             (rd_data_r[out_entry_r.bit_sel] ^ out_entry_r.invert) :
                             out_entry_r.force_on;
    result.redraw_pending  = out_entry_r.dirty;
    result.protocol_error  = out_entry_r.err;
    result.link_mode       = out_entry_r.link;
    result.display_enabled = out_entry_r.enable;
    result.mirror_on       = out_entry_r.mirror;
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = result;

endmodule

[design/oled_i2c_command_framebuffer_core.sv]
// ----------------------------------------------------------------------------
// oled_i2c_command_framebuffer_core
// Page-mode OLED controller: bus byte decoder, request queue, frame store.
// ----------------------------------------------------------------------------
// result path: an accepted word is written into a queue slot, then popped into the
//   result registers; the pop waits while a held result sees out_chan.ready low
// throughput: one word per cycle, unless the queue is full or the store is clearing
// reset: synchronous; afterwards a clearing pass over all COLUMNS*PAGES addresses
//   (1056 by default) zeroes the frame store while in_chan.ready stays low
module oled_i2c_command_framebuffer_core #(
  parameter int COLUMNS        = ocfb_pkg::COLUMNS_DEF,
  parameter int PAGES          = ocfb_pkg::PAGES_DEF,
  parameter int VISIBLE_WIDTH  = ocfb_pkg::VISIBLE_WIDTH_DEF,
  parameter int VISIBLE_HEIGHT = ocfb_pkg::VISIBLE_HEIGHT_DEF,
  parameter int COLUMN_OFFSET  = ocfb_pkg::COLUMN_OFFSET_DEF,
  parameter int QUEUE_DEPTH    = ocfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ocfb_stream_if.sink   in_chan,
  ocfb_stream_if.source out_chan
);
  import ocfb_pkg::*;

  fb_entry_t push_entry;
  fb_entry_t head_entry;
  logic      q_push;
  logic      q_pop;
  logic      q_empty;
  logic      q_full;
  logic      store_ready;

  ocfb_front #(
    .COLUMNS        (COLUMNS),
    .PAGES          (PAGES),
    .VISIBLE_WIDTH  (VISIBLE_WIDTH),
    .VISIBLE_HEIGHT (VISIBLE_HEIGHT),
    .COLUMN_OFFSET  (COLUMN_OFFSET)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .store_ready (store_ready),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (push_entry)
  );

  ocfb_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head_entry (head_entry),
    .empty      (q_empty),
    .full       (q_full)
  );

  ocfb_back #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_entry  (head_entry),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .store_ready (store_ready),
    .out_chan    (out_chan)
  );

endmodule
